/* sv/dht_pkg.sv */
`default_nettype none
package dht_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic hash_step;  // one byte of the hash
        logic hash_fin;   // final mix
        logic mod_start;  // start both remainders
        logic advance;    // move to next probe index
        logic wr_new;     // write key, hash, value, mark used
        logic wr_val;     // replace value only
        logic clr_start;  // start used-bit clearing sweep
        logic clr_step;   // clear one slot
        logic out_load;   // register result
        logic [2:0] status;
        logic give_val;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic used;
        logic match;
        logic probes_done;
        logic clr_last;
        logic hash_last;
    } t_sts;

    function automatic logic [31:0] oaat_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] oaat_final(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage
`default_nettype wire

/* sv/double_hash_table_engine.sv */
`default_nettype none
// open-addressed hash table with double hashing over one table ram.
// each request is an insert (mode 0), lookup (1) or clear (2); mode 3 answers
// not found. after reset the block sweeps the table with o_stall high before
// it takes its first request. a request hashes the key byte by byte, finishes
// the hash, takes the two remainders (hash mod size, hash mod size-2, side by
// side by reciprocal multiplication), then probes slot by slot (ram read, then
// compare) until a slot decides or every slot has been probed, and registers
// the result. clear sweeps the table. one request is in flight at a time;
// o_stall is high while busy and the result waits in an output register
// until taken.
module double_hash_table_engine #(
    parameter int TABLE_SIZE  = 1021,
    parameter int KEY_BYTES   = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_key_in,
    input  wire logic [31:0] i_value_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [2:0]  o_status,
    output logic      [31:0] o_value_out
);
    dht_pkg::t_cmd cmd;
    dht_pkg::t_sts sts;

    // sequencing of hash, remainders, probes and sweep
    dht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_mode(i_mode),
        .o_stall(o_stall), .o_valid(o_valid), .i_stall(i_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    // hash unit, probe index, table ram with used bits
    dht_datapath #(
        .TABLE_SIZE(TABLE_SIZE), .KEY_BYTES(KEY_BYTES), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_key(i_key_in),
        .i_value(i_value_in), .o_sts(sts), .o_status(o_status),
        .o_value(o_value_out)
    );
endmodule
`default_nettype wire

/* sv/dht_ram.sv */
`default_nettype none
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1021
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/dht_mod.sv */
`default_nettype none
// remainder by a constant divisor: reciprocal multiply for the quotient,
// then multiply back and subtract; o_done marks the registered remainder
module dht_mod #(
    parameter int DIV   = 1021,
    parameter int DIV_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_num,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_rem
);
    // with l = ceil(log2 DIV), ceil(2^(32+l) / DIV) gives an exact quotient
    // for every 32-bit numerator
    localparam int          SHIFT   = 32 + $clog2(DIV);
    localparam logic [64:0] RECIP_W = ((65'd1 << SHIFT) + 65'(DIV) - 65'd1) / 65'(DIV);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];
    localparam logic [31:0] DIV32   = 32'(DIV);

    logic [48:0]      r_plo, r_phi;
    logic [31:0]      r_num, r_quo;
    logic             r_v1, r_v2;
    logic [DIV_W-1:0] r_rem;
    logic [64:0]      n_prod;
    logic [31:0]      n_diff;

    always_comb begin
        n_prod = {r_phi, 16'd0} + {16'd0, r_plo};
        n_diff = r_num - r_quo * DIV32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            o_done <= r_v2;
        end
    end

    // split the numerator so each product stays near 16 by 33 bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_plo <= 49'(i_num[15:0]) * 49'(RECIP);
            r_phi <= 49'(i_num[31:16]) * 49'(RECIP);
        end
        r_quo <= 32'(n_prod >> SHIFT);
        r_rem <= n_diff[DIV_W-1:0];
    end

    assign o_rem = r_rem;
endmodule
`default_nettype wire

/* sv/dht_datapath.sv */
`default_nettype none
module dht_datapath #(
    parameter int TABLE_SIZE  = 1021,
    parameter int KEY_BYTES   = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire dht_pkg::t_cmd          i_cmd,
    input  wire logic [31:0]            i_key,
    input  wire logic [31:0]            i_value,
    output dht_pkg::t_sts               o_sts,
    output logic      [2:0]             o_status,
    output logic      [31:0]            o_value
);
    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int IW1 = IW + 1;
    localparam int DW  = $clog2(TABLE_SIZE + 1);
    localparam int RW  = 1 + 32 + 32 + VALUE_WIDTH;
    localparam logic [DW-1:0] SIZE_D = DW'(TABLE_SIZE);
    localparam logic [IW:0]   SIZE_S = IW1'(TABLE_SIZE);
    localparam logic [31:0] KMASK = (KEY_BYTES >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * KEY_BYTES)) - 64'd1);
    localparam int KBW = (KEY_BYTES > 3) ? $clog2(KEY_BYTES + 1) : 2;

    logic [31:0]          r_key, r_hash;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [KBW-1:0]       r_byte;
    logic [IW-1:0]        r_cur, r_step, r_clr;
    logic [DW-1:0]        r_nprobe;
    logic [IW:0]          n_sum;
    logic [IW-1:0]        rem_a, rem_b;
    logic                 done_a, done_b;
    logic [7:0]           n_byte;
    logic [RW-1:0]        rd_data, wr_data;
    logic [IW-1:0]        wr_addr;
    logic                 we;
    logic [VALUE_WIDTH-1:0] sv_val;
    logic [31:0]          s_key, s_hash;
    logic                 s_used;

    dht_mod #(.DIV(TABLE_SIZE), .DIV_W(IW)) u_mod_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_num(r_hash), .o_done(done_a), .o_rem(rem_a)
    );
    dht_mod #(.DIV(TABLE_SIZE - 2), .DIV_W(IW)) u_mod_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_num(r_hash), .o_done(done_b), .o_rem(rem_b)
    );

    // ram word: used bit, key, hash, value; the sweep writes zero words
    assign we      = i_cmd.wr_new | i_cmd.wr_val | i_cmd.clr_step;
    assign wr_addr = i_cmd.clr_step ? r_clr : r_cur;
    assign wr_data = i_cmd.clr_step ? '0 : {1'b1, r_key, r_hash, r_val};
    // replace keeps key and hash; those equal the stored ones on a match
    dht_ram #(.WIDTH(RW), .DEPTH(TABLE_SIZE)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(wr_addr), .i_wdata(wr_data),
        .i_raddr(r_cur), .o_rdata(rd_data)
    );
    assign s_used = rd_data[RW-1];
    assign s_key  = rd_data[RW-2 -: 32];
    assign s_hash = rd_data[VALUE_WIDTH +: 32];
    assign sv_val = rd_data[VALUE_WIDTH-1:0];

    always_comb begin
        n_byte = (32'(r_byte) < 32'd4) ? r_key[8*r_byte[1:0] +: 8] : 8'd0;
        n_sum  = {1'b0, r_cur} + {1'b0, r_step};
        if (n_sum >= SIZE_S) begin
            n_sum = n_sum - SIZE_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_key & KMASK;
            r_val  <= VALUE_WIDTH'(i_value);
            r_hash <= '0;
            r_byte <= '0;
        end
        if (i_cmd.hash_step) begin
            r_hash <= dht_pkg::oaat_byte(r_hash, n_byte);
            r_byte <= r_byte + KBW'(1);
        end
        if (i_cmd.hash_fin) begin
            r_hash <= dht_pkg::oaat_final(r_hash);
        end
        if (done_a) begin
            r_cur    <= rem_a;
            r_nprobe <= '0;
        end
        if (done_b) begin
            r_step <= rem_b + IW'(1);
        end
        if (i_cmd.advance) begin
            r_cur    <= n_sum[IW-1:0];
            r_nprobe <= r_nprobe + DW'(1);
        end
        if (i_cmd.out_load) begin
            o_status <= i_cmd.status;
            o_value  <= i_cmd.give_val ? 32'(sv_val) : 32'd0;
        end
    end

    always_comb begin
        o_sts.mod_done    = done_a;
        o_sts.used        = s_used;
        o_sts.match       = (s_hash == r_hash) && (s_key == r_key);
        o_sts.probes_done = (r_nprobe == SIZE_D);
        o_sts.clr_last    = (r_clr == IW'(TABLE_SIZE - 1));
        o_sts.hash_last   = (r_byte == KBW'(KEY_BYTES - 1));
    end

`ifndef ASSERT_OFF
    a_step_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> r_step != '0) else $error("zero probe step");
    a_cur_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance || i_cmd.wr_new) |-> r_cur < IW'(TABLE_SIZE))
        else $error("probe index out of range");
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_new && i_cmd.clr_step)) else $error("write during clear");
`endif
endmodule
`default_nettype wire

/* sv/dht_ctrl.sv */
`default_nettype none
module dht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_mode,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire dht_pkg::t_sts i_sts,
    output dht_pkg::t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HASH, S_FIN, S_MOD, S_WAIT, S_RD, S_CHK, S_CLR, S_OUT
    } t_state;

    t_state       r_state;
    dht_pkg::t_mode r_mode;
    logic         accept;

    assign accept  = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.status = dht_pkg::ST_NOT_FOUND;
        o_cmd.load = accept;
        case (r_state)
            S_INIT:  o_cmd.clr_step = 1'b1;
            S_HASH:  o_cmd.hash_step = 1'b1;
            S_FIN:   begin
                o_cmd.hash_fin = 1'b1;
            end
            S_MOD:   o_cmd.mod_start = 1'b1;
            S_CHK:   begin
                if (i_sts.probes_done) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.status = (r_mode == dht_pkg::MODE_INSERT) ?
                        dht_pkg::ST_FULL : dht_pkg::ST_NOT_FOUND;
                end else if (!i_sts.used) begin
                    o_cmd.out_load = 1'b1;
                    if (r_mode == dht_pkg::MODE_INSERT) begin
                        o_cmd.wr_new = 1'b1;
                        o_cmd.status = dht_pkg::ST_NEW;
                    end
                end else if (i_sts.match) begin
                    o_cmd.out_load = 1'b1;
                    if (r_mode == dht_pkg::MODE_INSERT) begin
                        o_cmd.wr_val = 1'b1;
                        o_cmd.status = dht_pkg::ST_REPLACED;
                    end else begin
                        o_cmd.status = dht_pkg::ST_FOUND;
                        o_cmd.give_val = 1'b1;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_CLR:   begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.status = dht_pkg::ST_CLEARED;
                end
            end
            S_IDLE:  begin
                if (accept && i_mode == dht_pkg::MODE_CLEAR) begin
                    o_cmd.clr_start = 1'b1;
                end
                if (accept && i_mode == dht_pkg::MODE_NONE) begin
                    o_cmd.out_load = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= dht_pkg::MODE_INSERT;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_INIT: if (i_sts.clr_last) r_state <= S_IDLE;
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= dht_pkg::t_mode'(i_mode);
                        case (dht_pkg::t_mode'(i_mode))
                            dht_pkg::MODE_CLEAR: r_state <= S_CLR;
                            dht_pkg::MODE_NONE: begin
                                r_state <= S_OUT;
                                o_valid <= 1'b1;
                            end
                            default: r_state <= S_HASH;
                        endcase
                    end
                end
                S_HASH: if (i_sts.hash_last) r_state <= S_FIN;
                S_FIN:  r_state <= S_MOD;
                S_MOD:  r_state <= S_WAIT;
                S_WAIT: if (i_sts.mod_done) r_state <= S_RD;
                S_RD:   r_state <= S_CHK;
                S_CHK: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_CLR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                        o_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_vout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result valid outside output state");
    a_one_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_new && o_cmd.wr_val)) else $error("double write");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* bench/testbench.sv */
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 1021;
    localparam int MAX_CYC   = 3000000;

    typedef struct packed {
        dht_pkg::t_mode mode;
        logic [31:0]    key;
        logic [31:0]    value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } t_rsp;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_mode;
    logic [31:0] in_key;
    logic [31:0] in_value;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  out_status;
    logic [31:0] out_value;

    double_hash_table_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_mode      (in_mode),
        .i_key_in    (in_key),
        .i_value_in  (in_value),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_status    (out_status),
        .o_value_out (out_value)
    );

    // shadow copy of the table
    logic        tbl_used  [SLOTS];
    logic [31:0] tbl_key   [SLOTS];
    logic [31:0] tbl_hash  [SLOTS];
    logic [31:0] tbl_value [SLOTS];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    logic [31:0] known_keys[$];

    int errors;
    int cycles;
    int idle_pct;       // sender idle chance in percent
    int stall_pct;      // receiver stall chance in percent
    int hold_cycles;    // long receiver hold-off, counted down
    bit feeding_done;

    // clock
    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] oaat_of_key(input logic [31:0] k);
        logic [31:0] h;
        h = 32'd0;
        for (int i = 0; i < 4; i++) begin
            h = h + {24'd0, k[8*i +: 8]};
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // apply one request to the shadow table and return its result
    function automatic t_rsp table_apply(input t_req r);
        t_rsp        res;
        logic [31:0] h;
        int unsigned pos, stride;
        res.status = dht_pkg::ST_NOT_FOUND;
        res.value  = 32'd0;
        if (r.mode == dht_pkg::MODE_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
            res.status = dht_pkg::ST_CLEARED;
            return res;
        end
        if (r.mode == dht_pkg::MODE_NONE) return res;
        h      = oaat_of_key(r.key);
        pos    = h % SLOTS;
        stride = h % (SLOTS - 2) + 1;
        if (r.mode == dht_pkg::MODE_INSERT) res.status = dht_pkg::ST_FULL;
        for (int n = 0; n < SLOTS; n++) begin
            if (!tbl_used[pos]) begin
                if (r.mode == dht_pkg::MODE_INSERT) begin
                    tbl_used[pos]  = 1'b1;
                    tbl_key[pos]   = r.key;
                    tbl_hash[pos]  = h;
                    tbl_value[pos] = r.value;
                    res.status     = dht_pkg::ST_NEW;
                end
                return res;
            end
            if (tbl_hash[pos] == h && tbl_key[pos] == r.key) begin
                if (r.mode == dht_pkg::MODE_INSERT) begin
                    tbl_value[pos] = r.value;
                    res.status     = dht_pkg::ST_REPLACED;
                end else begin
                    res.status = dht_pkg::ST_FOUND;
                    res.value  = tbl_value[pos];
                end
                return res;
            end
            pos = (pos + stride) % SLOTS;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic queue_req(input dht_pkg::t_mode m, input logic [31:0] k,
                             input logic [31:0] v);
        t_req r;
        r.mode  = m;
        r.key   = k;
        r.value = v;
        pending_reqs.push_back(r);
        if (m == dht_pkg::MODE_INSERT) known_keys.push_back(k);
        if (m == dht_pkg::MODE_CLEAR) known_keys.delete();
    endtask

    function automatic logic [31:0] pick_key();
        if (known_keys.size() > 0 && $urandom_range(0, 99) < 60)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return $urandom();
    endfunction

    // driver: offers the head of the pending queue, predicts on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
            end
            // keep a stalled request steady
            if (!(in_valid && in_stall)) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_mode  <= pending_reqs[0].mode;
                    in_key   <= pending_reqs[0].key;
                    in_value <= pending_reqs[0].value;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // acceptance above reads the queue head before it is popped, so the
    // offered request is always pending_reqs[0]

    // monitor: checks each accepted result against the oldest expectation
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result", {29'd0, out_status}, 32'd0);
                end else begin
                    t_rsp e;
                    e = expected_rsps.pop_front();
                    if (out_status !== e.status)
                        report_mismatch("status", {29'd0, out_status}, {29'd0, e.status});
                    if (out_value !== e.value)
                        report_mismatch("value_out", out_value, e.value);
                end
            end
        end
    end

    // receiver: random stall, long hold-off counted down here
    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_cycles > 0) begin
                out_stall   <= 1'b1;
                hold_cycles <= hold_cycles - 1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    endtask

    initial begin
        int n;
        dht_pkg::t_mode m;
        errors      = 0;
        cycles      = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_mode     = dht_pkg::MODE_INSERT;
        in_key      = 32'd0;
        in_value    = 32'd0;
        out_stall   = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = 32'd0;
            tbl_hash[i] = 32'd0;
            tbl_value[i] = 32'd0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every mode, replace, miss, unused mode, clear
        queue_req(dht_pkg::MODE_LOOKUP, 32'd0, 32'd0);
        queue_req(dht_pkg::MODE_INSERT, 32'd0, 32'hFFFF_FFFF);
        queue_req(dht_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'd0);
        queue_req(dht_pkg::MODE_LOOKUP, 32'd0, 32'd0);
        queue_req(dht_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(dht_pkg::MODE_INSERT, 32'd0, 32'hA5A5_5A5A);
        queue_req(dht_pkg::MODE_LOOKUP, 32'd0, 32'd0);
        queue_req(dht_pkg::MODE_LOOKUP, 32'h1234_5678, 32'd0);
        queue_req(dht_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(dht_pkg::MODE_NONE, 32'd0, 32'd0);
        queue_req(dht_pkg::MODE_INSERT, 32'h8000_0001, 32'h7FFF_FFFE);
        queue_req(dht_pkg::MODE_LOOKUP, 32'h8000_0001, 32'd0);
        queue_req(dht_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(dht_pkg::MODE_LOOKUP, 32'd0, 32'd0);
        queue_req(dht_pkg::MODE_LOOKUP, 32'h8000_0001, 32'd0);
        queue_req(dht_pkg::MODE_INSERT, 32'h8000_0001, 32'h1);
        wait_drained();

        // random phases, long hold-off in the second one
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 0;  stall_pct = 0;  hold_cycles = 400; end
                2: begin idle_pct = 69; stall_pct = 0;  end
                3: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            n = (ph == 0) ? 30 : 20;
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 99)) inside
                    [0:49]:  m = dht_pkg::MODE_INSERT;
                    [50:93]: m = dht_pkg::MODE_LOOKUP;
                    [94:96]: m = dht_pkg::MODE_NONE;
                    default: m = dht_pkg::MODE_CLEAR;
                endcase
                queue_req(m, pick_key(), $urandom());
            end
            wait_drained();
        end

        // fill the table to full, then probe replace and full insert
        idle_pct  = 0;
        stall_pct = 0;
        queue_req(dht_pkg::MODE_CLEAR, 32'd0, 32'd0);
        for (int i = 0; i < SLOTS; i++)
            queue_req(dht_pkg::MODE_INSERT, i * 32'd7919 + 5, $urandom());
        queue_req(dht_pkg::MODE_INSERT, 32'hDEAD_BEEF, 32'd1);
        queue_req(dht_pkg::MODE_INSERT, 32'd5, 32'hCAFE_F00D);
        queue_req(dht_pkg::MODE_LOOKUP, 32'd5, 32'd0);
        queue_req(dht_pkg::MODE_LOOKUP, 32'hDEAD_BEEF, 32'd0);
        wait_drained();

        repeat (1200) @(posedge clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
